[hw/rtl/swpg_pkg.sv]
`timescale 1ns / 1ps

package swpg_pkg;

    // Default sizes
    localparam int MAX_ELEMS_DEF  = 8;
    localparam int VALUE_BITS_DEF = 16;

    // Fixed field widths
    localparam int SIZE_W      = 4;
    localparam int LOAD_IDX_W  = 3;
    localparam int POS_W       = 3;
    localparam logic [SIZE_W-1:0] PERM_SIZE_RST = 4'd4;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap_load;     // latch load index/value, mark load pending
        logic cfg_ack;      // restart request taken
        logic lvl_load;     // working level <= current level
        logic lvl_dec;      // working level <= working level - 1
        logic sw_rd;        // read both swap operands
        logic sw_w1;        // write first swap operand
        logic sw_w2;        // write second swap operand
        logic adv_bump;     // try next choice at working level
        logic clear_state;  // end of restart: clear counters, apply pending load
        logic first_start;  // set up first permutation
        logic set_done;     // enumeration exhausted
        logic em_start;     // prefetch element 0
        logic em_push;      // push one element into the output register
        logic exh_push;     // push the exhausted item
    } swpg_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic rst_req;      // size register written, restart owed
        logic lvl_zero;     // working level is zero
        logic started;
        logic done;
        logic bump_ok;      // next choice exists at working level
        logic k_last;       // element counter at last position
        logic out_free;     // output register can take an item
    } swpg_sts_t;

endpackage

[hw/rtl/swpg_ctrl.sv]
`timescale 1ns / 1ps

module swpg_ctrl
    import swpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_req_type,
    output logic      in_ready,
    input  swpg_sts_t sts,
    output swpg_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_UNW_CHK  = 4'd1;
    localparam logic [3:0] ST_SW_RD    = 4'd2;
    localparam logic [3:0] ST_SW_W1    = 4'd3;
    localparam logic [3:0] ST_SW_W2    = 4'd4;
    localparam logic [3:0] ST_ADV_CHK  = 4'd5;
    localparam logic [3:0] ST_ADV_BUMP = 4'd6;
    localparam logic [3:0] ST_EM_START = 4'd7;
    localparam logic [3:0] ST_EM_LOOP  = 4'd8;
    localparam logic [3:0] ST_EXH      = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;

    // State and swap return registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !sts.rst_req;
                if (sts.rst_req)
                begin
                    cmd.cfg_ack  = 1'b1;
                    cmd.lvl_load = 1'b1;
                    state_next   = ST_UNW_CHK;
                end
                else if (in_valid)
                begin
                    if (in_req_type == REQ_LOAD)
                    begin
                        cmd.cap_load = 1'b1;
                        cmd.lvl_load = 1'b1;
                        state_next   = ST_UNW_CHK;
                    end
                    else if (sts.done)
                    begin
                        state_next = ST_EXH;
                    end
                    else if (!sts.started)
                    begin
                        cmd.first_start = 1'b1;
                        state_next      = ST_EM_START;
                    end
                    else
                    begin
                        cmd.lvl_load = 1'b1;
                        state_next   = ST_ADV_CHK;
                    end
                end
            end
            // undo active swaps, deepest first
            ST_UNW_CHK:
            begin
                if (sts.lvl_zero)
                begin
                    cmd.clear_state = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.lvl_dec = 1'b1;
                    ret_next    = ST_UNW_CHK;
                    state_next  = ST_SW_RD;
                end
            end
            ST_SW_RD:
            begin
                cmd.sw_rd  = 1'b1;
                state_next = ST_SW_W1;
            end
            ST_SW_W1:
            begin
                cmd.sw_w1  = 1'b1;
                state_next = ST_SW_W2;
            end
            ST_SW_W2:
            begin
                cmd.sw_w2  = 1'b1;
                state_next = ret_reg;
            end
            // pop levels until one has a further choice
            ST_ADV_CHK:
            begin
                if (sts.lvl_zero)
                begin
                    cmd.set_done = 1'b1;
                    state_next   = ST_EXH;
                end
                else
                begin
                    cmd.lvl_dec = 1'b1;
                    ret_next    = ST_ADV_BUMP;
                    state_next  = ST_SW_RD;
                end
            end
            ST_ADV_BUMP:
            begin
                cmd.adv_bump = 1'b1;
                if (sts.bump_ok)
                begin
                    ret_next   = ST_EM_START;
                    state_next = ST_SW_RD;
                end
                else
                begin
                    state_next = ST_ADV_CHK;
                end
            end
            ST_EM_START:
            begin
                cmd.em_start = 1'b1;
                state_next   = ST_EM_LOOP;
            end
            ST_EM_LOOP:
            begin
                if (sts.out_free)
                begin
                    cmd.em_push = 1'b1;
                    if (sts.k_last)
                        state_next = ST_IDLE;
                end
            end
            ST_EXH:
            begin
                if (sts.out_free)
                begin
                    cmd.exh_push = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/swpg_dp.sv]
`timescale 1ns / 1ps

module swpg_dp
    import swpg_pkg::*;
#(
    parameter int MAX_ELEMS  = MAX_ELEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [SIZE_W-1:0]     cfg_wr_data,
    input  swpg_cmd_t             cmd,
    output swpg_sts_t             sts,
    input  logic [LOAD_IDX_W-1:0] in_index,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] out_value,
    output logic [POS_W-1:0]      out_pos,
    output logic                  out_last,
    output logic                  out_exh
);

    localparam int IDX_W = $clog2(MAX_ELEMS);
    localparam int NW    = $clog2(MAX_ELEMS + 1);

    logic [SIZE_W-1:0]     perm_size_reg;
    logic                  rst_pend_reg;
    logic                  ld_pend_reg;
    logic [LOAD_IDX_W-1:0] ld_idx_reg;
    logic [VALUE_BITS-1:0] ld_val_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      lvl_reg;
    logic                  started_reg;
    logic                  done_reg;
    logic [IDX_W-1:0]      cnt_reg [MAX_ELEMS];
    logic [IDX_W-1:0]      k_reg;
    logic [VALUE_BITS-1:0] mem [MAX_ELEMS];
    logic [VALUE_BITS-1:0] rd_a_reg;
    logic [VALUE_BITS-1:0] rd_b_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic                  out_last_reg;
    logic                  out_exh_reg;

    logic [NW-1:0]         n;
    logic [IDX_W-1:0]      n_m1;
    logic [IDX_W-1:0]      cnt_at;
    logic [IDX_W:0]        bump_c;
    logic                  bump_ok;
    logic                  out_free;
    logic                  ld_ok;
    logic                  we;
    logic [IDX_W-1:0]      wa;
    logic [VALUE_BITS-1:0] wd;
    logic                  re_a;
    logic [IDX_W-1:0]      ra;

    // Active size, clamped to 1..MAX_ELEMS
    always_comb
    begin
        if (perm_size_reg == '0)
            n = NW'(1);
        else if (perm_size_reg > MAX_ELEMS)
            n = NW'(MAX_ELEMS);
        else
            n = NW'(perm_size_reg);
    end

    assign n_m1     = IDX_W'(n - NW'(1));
    assign cnt_at   = cnt_reg[lvl_reg];
    assign bump_c   = {1'b0, cnt_at} + (IDX_W+1)'(1);
    assign bump_ok  = bump_c < (IDX_W+1)'(n);
    assign out_free = !out_valid_reg || out_ready;
    assign ld_ok    = ld_pend_reg && (ld_idx_reg < MAX_ELEMS);

    assign sts.rst_req  = rst_pend_reg;
    assign sts.lvl_zero = (lvl_reg == '0);
    assign sts.started  = started_reg;
    assign sts.done     = done_reg;
    assign sts.bump_ok  = bump_ok;
    assign sts.k_last   = (k_reg == n_m1);
    assign sts.out_free = out_free;

    // Size register and restart request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_size_reg <= PERM_SIZE_RST;
            rst_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                perm_size_reg <= cfg_wr_data;
                rst_pend_reg  <= 1'b1;
            end
            else if (cmd.cfg_ack)
            begin
                rst_pend_reg <= 1'b0;
            end
        end
    end

    // Pending load item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ld_pend_reg <= 1'b0;
        else if (cmd.cap_load)
            ld_pend_reg <= 1'b1;
        else if (cmd.clear_state)
            ld_pend_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_load)
        begin
            ld_idx_reg <= in_index;
            ld_val_reg <= in_value;
        end
    end

    // Level stack control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            lvl_reg     <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            if (cmd.lvl_load)
                lvl_reg <= cur_reg;
            else if (cmd.lvl_dec)
                lvl_reg <= lvl_reg - IDX_W'(1);

            if (cmd.clear_state || cmd.set_done)
                cur_reg <= '0;
            else if (cmd.first_start || (cmd.adv_bump && bump_ok))
                cur_reg <= n_m1;

            if (cmd.clear_state || cmd.set_done)
                started_reg <= 1'b0;
            else if (cmd.first_start)
                started_reg <= 1'b1;

            if (cmd.clear_state)
                done_reg <= 1'b0;
            else if (cmd.set_done)
                done_reg <= 1'b1;

            if (cmd.em_start)
                k_reg <= '0;
            else if (cmd.em_push)
                k_reg <= k_reg + IDX_W'(1);
        end
    end

    // Per-level loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MAX_ELEMS; m++)
                cnt_reg[m] <= '0;
        end
        else
        begin
            for (int m = 0; m < MAX_ELEMS; m++)
            begin
                if (cmd.clear_state)
                    cnt_reg[m] <= '0;
                else if (cmd.first_start && (m < n_m1))
                    cnt_reg[m] <= IDX_W'(m);
                else if (cmd.adv_bump)
                begin
                    if (m == lvl_reg)
                        cnt_reg[m] <= bump_ok ? bump_c[IDX_W-1:0] : '0;
                    else if (bump_ok && (m > lvl_reg) && (m < n_m1))
                        cnt_reg[m] <= IDX_W'(m);
                end
            end
        end
    end

    // Element store: one write port, two registered read ports
    always_comb
    begin
        we = 1'b0;
        wa = lvl_reg;
        wd = rd_b_reg;
        if (cmd.sw_w1)
        begin
            we = 1'b1;
        end
        else if (cmd.sw_w2)
        begin
            we = 1'b1;
            wa = cnt_at;
            wd = rd_a_reg;
        end
        else if (cmd.clear_state && ld_ok)
        begin
            we = 1'b1;
            wa = IDX_W'(ld_idx_reg);
            wd = ld_val_reg;
        end
    end

    assign re_a = cmd.sw_rd || cmd.em_start || cmd.em_push;

    always_comb
    begin
        if (cmd.sw_rd)
            ra = lvl_reg;
        else if (cmd.em_start)
            ra = '0;
        else
            ra = k_reg + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re_a)
            rd_a_reg <= mem[ra];
        if (cmd.sw_rd)
            rd_b_reg <= mem[cnt_at];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.em_push || cmd.exh_push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.em_push)
        begin
            out_value_reg <= rd_a_reg;
            out_pos_reg   <= POS_W'(k_reg);
            out_last_reg  <= (k_reg == n_m1);
            out_exh_reg   <= 1'b0;
        end
        else if (cmd.exh_push)
        begin
            out_value_reg <= '0;
            out_pos_reg   <= '0;
            out_last_reg  <= 1'b1;
            out_exh_reg   <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_pos   = out_pos_reg;
    assign out_last  = out_last_reg;
    assign out_exh   = out_exh_reg;

endmodule

[hw/rtl/swap_permutation_generator_core.sv]
`timescale 1ns / 1ps
// Next request, first permutation: element 0 is prefetched, then one per cycle unless stalled.
// Next request later: per level examined: check, read, write, write, bump; the new swap is read and
//   written, element 0 is prefetched, and n elements follow at one per cycle unless stalled.
// Load/size write: undo each active level (check, read, write, write); no item is taken meanwhile.
// Reset (rst_n low, async): size 4, enumeration restarted; element store is not cleared.

module swap_permutation_generator_core
    import swpg_pkg::*;
#(
    parameter int MAX_ELEMS  = MAX_ELEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // size register
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    // request items
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: load_index, load_value, zero pad
    input  logic [((LOAD_IDX_W+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: req_type
    input  logic              s_axis_tuser,
    // result items
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tdata: elem_value, elem_pos, zero pad
    output logic [((VALUE_BITS+POS_W+7)/8)*8-1:0] m_axis_tdata,
    output logic              m_axis_tlast,
    // tuser: exhausted
    output logic              m_axis_tuser
);

    localparam int OUT_W = ((VALUE_BITS + POS_W + 7) / 8) * 8;

    swpg_cmd_t             cmd;
    swpg_sts_t             sts;
    logic [VALUE_BITS-1:0] out_value;
    logic [POS_W-1:0]      out_pos;

    swpg_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_req_type (s_axis_tuser),
        .in_ready    (s_axis_tready),
        .sts         (sts),
        .cmd         (cmd)
    );

    swpg_dp #(
        .MAX_ELEMS  (MAX_ELEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .in_index    (s_axis_tdata[LOAD_IDX_W-1:0]),
        .in_value    (s_axis_tdata[LOAD_IDX_W+VALUE_BITS-1:LOAD_IDX_W]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (out_value),
        .out_pos     (out_pos),
        .out_last    (m_axis_tlast),
        .out_exh     (m_axis_tuser)
    );

    // Pack result fields
    assign m_axis_tdata = OUT_W'({out_pos, out_value});

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import swpg_pkg::*;

    localparam int N_ELEMS    = MAX_ELEMS_DEF;
    localparam int VAL_W      = VALUE_BITS_DEF;
    localparam int IN_W       = ((LOAD_IDX_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_W      = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int ITEM_GOAL  = 430;
    localparam int SETTLE_CYC = 64;     // covers a restart that undoes every active level
    localparam int HOLD_CYC   = 400;
    localparam int HOLD_AFTER = 150;
    localparam longint LIMIT_NS = 64'd12_000_000;

    // One result item as it leaves the block
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             exh;
    } elem_item_t;

    typedef enum logic [1:0] { ROW_SIZE, ROW_LOAD, ROW_NEXT } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [SIZE_W-1:0]     size;
        logic [LOAD_IDX_W-1:0] idx;
        logic [VAL_W-1:0]      value;
        logic                  typed;
        elem_item_t            want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;    // load_index, load_value, zero pad
    logic              s_axis_tuser;    // req_type
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;    // elem_value, elem_pos, zero pad
    logic              m_axis_tlast;
    logic              m_axis_tuser;    // exhausted

    // Predictor state: element list, per-level loop counters, run flags
    logic [VAL_W-1:0]  perm_elems [N_ELEMS];
    int unsigned       perm_ctr [N_ELEMS];
    int unsigned       perm_level;
    bit                perm_started;
    bit                perm_done;
    logic [SIZE_W-1:0] perm_size;
    elem_item_t        step_items [N_ELEMS];
    int                step_len;

    elem_item_t        expected_elems [$];
    stim_row_t         dir_rows [$];

    bit                no_idle;
    int                fails;
    int                items_sent;
    int                n_load, n_next, n_size, n_results, n_exh;

    always #4 clk = ~clk;

    swap_permutation_generator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Size register as the block sees it: 0 acts as 1, large values clamp
    function automatic int unsigned active_len();
        if (perm_size == 0)
            return 1;
        if (perm_size > N_ELEMS)
            return N_ELEMS;
        return perm_size;
    endfunction

    function automatic void swap_elems(int unsigned p, int unsigned q);
        logic [VAL_W-1:0] t;
        t             = perm_elems[p];
        perm_elems[p] = perm_elems[q];
        perm_elems[q] = t;
    endfunction

    // Restart: undo active swaps from the deepest level up, clear the stack
    function automatic void undo_swaps();
        int unsigned l;
        l = perm_level;
        if (perm_started)
        begin
            while (l > 0)
            begin
                l--;
                swap_elems(l, perm_ctr[l]);
            end
        end
        foreach (perm_ctr[i])
            perm_ctr[i] = 0;
        perm_level   = 0;
        perm_started = 1'b0;
        perm_done    = 1'b0;
    endfunction

    function automatic elem_item_t mk_item(logic [VAL_W-1:0] v, logic [POS_W-1:0] p,
                                           logic l, logic e);
        elem_item_t it;
        it.value = v;
        it.pos   = p;
        it.last  = l;
        it.exh   = e;
        return it;
    endfunction

    function automatic void emit_exhausted();
        step_items[0] = mk_item('0, '0, 1'b1, 1'b1);
        step_len      = 1;
    endfunction

    function automatic void emit_perm(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            step_items[k] = mk_item(perm_elems[k], POS_W'(k), (k + 1 == n), 1'b0);
        step_len = n;
    endfunction

    // Next request: walk the counter stack to the next leaf
    function automatic void enum_next();
        int unsigned n, l, c, m;
        n = active_len();
        if (perm_done)
        begin
            emit_exhausted();
            return;
        end
        if (!perm_started)
        begin
            for (m = 0; m + 1 < n; m++)
                perm_ctr[m] = m;
            perm_level   = n - 1;
            perm_started = 1'b1;
            emit_perm(n);
            return;
        end
        // pop levels until one has a further choice
        l = perm_level;
        while (l > 0)
        begin
            l--;
            swap_elems(l, perm_ctr[l]);
            c = perm_ctr[l] + 1;
            if (c < n)
            begin
                perm_ctr[l] = c;
                swap_elems(l, c);
                for (m = l + 1; m + 1 < n; m++)
                    perm_ctr[m] = m;
                perm_level = n - 1;
                emit_perm(n);
                return;
            end
            perm_ctr[l] = 0;
        end
        perm_level   = 0;
        perm_started = 1'b0;
        perm_done    = 1'b1;
        emit_exhausted();
    endfunction

    function automatic void add_row(row_kind_t kind, logic [SIZE_W-1:0] size,
                                    logic [LOAD_IDX_W-1:0] idx, logic [VAL_W-1:0] value,
                                    logic typed, elem_item_t want);
        stim_row_t r;
        r.kind  = kind;
        r.size  = size;
        r.idx   = idx;
        r.value = value;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(VAL_W-1){1'b0}}};
            1:       return {1'b0, {(VAL_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Wait until every expected item is out and any restart has finished
    task automatic settle_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_elems.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Size rows go through the register port while idle; others are request items
    task automatic run_row(input stim_row_t row);
        int unsigned gap;
        if (row.kind == ROW_SIZE)
        begin
            settle_block();
            @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= row.size;
            @(posedge clk);
            undo_swaps();
            perm_size = row.size;
            n_size++;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
        end
        else
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= (row.kind == ROW_NEXT) ? REQ_NEXT : REQ_LOAD;
            s_axis_tdata  <= IN_W'({row.value, row.idx});
            do
                @(posedge clk);
            while (!s_axis_tready);
            if (row.kind == ROW_NEXT)
            begin
                n_next++;
                enum_next();
            end
            else
            begin
                n_load++;
                undo_swaps();
                perm_elems[row.idx] = row.value;
                step_len = 0;
            end
            if (row.typed)
                expected_elems.push_back(row.want);
            else
                for (int k = 0; k < step_len; k++)
                    expected_elems.push_back(step_items[k]);
            items_sent++;
            gap = pick_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Result checker: compare each accepted item with the oldest expectation
    always @(posedge clk)
    begin : check_out
        elem_item_t got;
        elem_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value = m_axis_tdata[VAL_W-1:0];
            got.pos   = m_axis_tdata[VAL_W +: POS_W];
            got.last  = m_axis_tlast;
            got.exh   = m_axis_tuser;
            n_results++;
            if (got.exh)
                n_exh++;
            if (expected_elems.size() == 0)
            begin
                $error("result item with nothing expected: value %0d pos %0d",
                       $signed(got.value), got.pos);
                fails++;
            end
            else
            begin
                want = expected_elems.pop_front();
                if (got.value !== want.value)
                begin
                    $error("elem_value: expected %0d, got %0d",
                           $signed(want.value), $signed(got.value));
                    fails++;
                end
                if (got.pos !== want.pos)
                begin
                    $error("elem_pos: expected %0d, got %0d", want.pos, got.pos);
                    fails++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    fails++;
                end
                if (got.exh !== want.exh)
                begin
                    $error("exhausted: expected %0d, got %0d", want.exh, got.exh);
                    fails++;
                end
            end
        end
    end

    // Result side backpressure, with one long hold-off to back up the block;
    // the hold-off starts while a request item is on offer
    initial
    begin : result_sink
        int unsigned gap;
        bit held;
        m_axis_tready = 1'b0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && n_results >= HOLD_AFTER && s_axis_tvalid)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC) @(negedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t   row;
        elem_item_t  exh_item;
        elem_item_t  no_item;
        int unsigned n, lim, nexts, sz;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOAD;
        no_idle       = 1'b0;
        fails         = 0;
        items_sent    = 0;
        n_load = 0; n_next = 0; n_size = 0; n_results = 0; n_exh = 0;

        // predictor after reset
        foreach (perm_elems[i])
            perm_elems[i] = '0;
        perm_started = 1'b0;
        undo_swaps();
        perm_size = PERM_SIZE_RST;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        exh_item = mk_item('0, '0, 1'b1, 1'b1);
        no_item  = '0;

        // size 1: single element, then exhaustion, repeated
        add_row(ROW_SIZE, 4'd1, 0, 0, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd0, 16'h8000, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b1, mk_item(16'h8000, 0, 1'b1, 1'b0));
        add_row(ROW_NEXT, 0, 0, 0, 1'b1, exh_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b1, exh_item);
        // a load restarts an exhausted run
        add_row(ROW_LOAD, 0, 3'd0, 16'h7fff, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b1, mk_item(16'h7fff, 0, 1'b1, 1'b0));
        // size 0 acts as size 1
        add_row(ROW_SIZE, 4'd0, 0, 0, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b1, mk_item(16'h7fff, 0, 1'b1, 1'b0));
        add_row(ROW_NEXT, 0, 0, 0, 1'b1, exh_item);
        // size 15 clamps to the full list; fill every position
        add_row(ROW_SIZE, 4'd15, 0, 0, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd0, 16'h8000, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd1, 16'hffff, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd2, 16'h0000, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd3, 16'h0001, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd4, 16'h7fff, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd5, 16'h5a5a, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd6, 16'ha5a5, 1'b0, no_item);
        add_row(ROW_LOAD, 0, 3'd7, 16'h1234, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b0, no_item);
        // load in the middle of a run: swaps are undone first
        add_row(ROW_LOAD, 0, 3'd3, 16'h0f0f, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b0, no_item);
        // size 2: both orders, then exhausted
        add_row(ROW_SIZE, 4'd2, 0, 0, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b1, exh_item);
        add_row(ROW_SIZE, 4'd8, 0, 0, 1'b0, no_item);
        add_row(ROW_NEXT, 0, 0, 0, 1'b0, no_item);

        foreach (dir_rows[i])
            run_row(dir_rows[i]);

        // random phases: new size, reload, then a run of next requests
        while (items_sent < ITEM_GOAL)
        begin
            case ($urandom_range(0, 19))
                0:       sz = 0;
                1:       sz = $urandom_range(9, 15);
                2, 3, 4: sz = $urandom_range(6, 8);
                default: sz = $urandom_range(1, 5);
            endcase
            row = '0;
            row.kind = ROW_SIZE;
            row.size = SIZE_W'(sz);
            run_row(row);
            no_idle = ($urandom_range(0, 5) == 0);
            n = active_len();

            // reload most of the active positions, some others too
            for (int k = 0; k < N_ELEMS; k++)
            begin
                if ((k < n && $urandom_range(0, 9) < 7) || $urandom_range(0, 9) == 0)
                begin
                    row.kind  = ROW_LOAD;
                    row.idx   = LOAD_IDX_W'(k);
                    row.value = rand_value();
                    run_row(row);
                end
            end

            // small sizes often run through to exhaustion
            case (n)
                1:       lim = 1;
                2:       lim = 2;
                3:       lim = 6;
                4:       lim = 24;
                default: lim = 0;
            endcase
            if (lim == 0)
                nexts = $urandom_range(4, 30);
            else if ($urandom_range(0, 1) == 0)
                nexts = lim + $urandom_range(1, 3);
            else
                nexts = $urandom_range(1, lim + 3);

            for (int j = 0; j < nexts; j++)
            begin
                row.kind  = ($urandom_range(0, 11) == 0) ? ROW_LOAD : ROW_NEXT;
                row.idx   = LOAD_IDX_W'($urandom);
                row.value = rand_value();
                run_row(row);
            end
            no_idle = 1'b0;
        end

        settle_block();
        $display("run covered %0d loads, %0d next requests and %0d size writes",
                 n_load, n_next, n_size);
        $display("%0d result items checked, %0d of them exhausted markers",
                 n_results, n_exh);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[swap_permutation_generator_core.f]
hw/rtl/swpg_pkg.sv
hw/rtl/swpg_ctrl.sv
hw/rtl/swpg_dp.sv
hw/rtl/swap_permutation_generator_core.sv
test/testbench.sv
